[hdl/motion_rep_counter_unit_macros.svh]
// Assertion helpers for the rep counter block; clk and rst_n come from the
// module that uses them.
`ifndef MOTION_REP_COUNTER_UNIT_MACROS_SVH
`define MOTION_REP_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication
`define MRC_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion_rep_counter_unit: same-cycle check failed");

// Next-cycle implication
`define MRC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion_rep_counter_unit: next-cycle check failed");

`endif

[hdl/mrc_pkg.sv]
`default_nettype none

package mrc_pkg;

    localparam int COUNT_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STEPS_DEF    = 16;

    // atan table: degrees scaled by 2^TABLE_FRAC
    localparam int TABLE_SIZE = 24;
    localparam int TABLE_FRAC = 24;
    localparam int TAB_IDX_W  = 5;

    // Configuration register indexes
    localparam logic [2:0] CFG_SQUAT_DOWN  = 3'd0;
    localparam logic [2:0] CFG_SQUAT_UP    = 3'd1;
    localparam logic [2:0] CFG_CURL_START  = 3'd2;
    localparam logic [2:0] CFG_CURL_END    = 3'd3;
    localparam logic [2:0] CFG_RAISE_START = 3'd4;
    localparam logic [2:0] CFG_RAISE_END   = 3'd5;

    localparam logic [15:0] SQUAT_DOWN_RST  = 16'd3550;
    localparam logic [15:0] SQUAT_UP_RST    = 16'd4803;
    localparam logic [7:0]  CURL_START_RST  = 8'd150;
    localparam logic [7:0]  CURL_END_RST    = 8'd60;
    localparam logic [7:0]  RAISE_START_RST = 8'd150;
    localparam logic [7:0]  RAISE_END_RST   = 8'd100;

    // Exercise codes
    localparam logic [1:0] EX_SQUAT = 2'd0;
    localparam logic [1:0] EX_CURL  = 2'd1;
    localparam logic [1:0] EX_RAISE = 2'd2;
    localparam logic [1:0] EX_NONE  = 2'd3;

    // Phase codes
    localparam logic [1:0] ARM_REST  = 2'd0;
    localparam logic [1:0] ARM_LIFT  = 2'd1;
    localparam logic [1:0] ARM_LOWER = 2'd2;
    localparam logic [1:0] SQ_REST   = 2'd0;
    localparam logic [1:0] SQ_DOWN   = 2'd1;
    localparam logic [1:0] SQ_UP     = 2'd2;

    // Operands of the shared squarer
    localparam logic [2:0] TERM_X    = 3'd0;
    localparam logic [2:0] TERM_Y    = 3'd1;
    localparam logic [2:0] TERM_Z    = 3'd2;
    localparam logic [2:0] TERM_DOWN = 3'd3;
    localparam logic [2:0] TERM_UP   = 3'd4;

    localparam logic [7:0] TILT_LEVEL = 8'd90;
    localparam logic [7:0] TILT_MAX   = 8'd180;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_SQRT,
        ST_CORDIC,
        ST_ANGLE,
        ST_FINISH
    } state_t;

    function automatic logic [31:0] atan_deg_q24(input logic [TAB_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd754974720;
            5'd1:    v = 32'd445687602;
            5'd2:    v = 32'd235489088;
            5'd3:    v = 32'd119537938;
            5'd4:    v = 32'd60000934;
            5'd5:    v = 32'd30029717;
            5'd6:    v = 32'd15018523;
            5'd7:    v = 32'd7509720;
            5'd8:    v = 32'd3754917;
            5'd9:    v = 32'd1877466;
            5'd10:   v = 32'd938734;
            5'd11:   v = 32'd469367;
            5'd12:   v = 32'd234684;
            5'd13:   v = 32'd117342;
            5'd14:   v = 32'd58671;
            5'd15:   v = 32'd29335;
            5'd16:   v = 32'd14668;
            5'd17:   v = 32'd7334;
            5'd18:   v = 32'd3667;
            5'd19:   v = 32'd1833;
            5'd20:   v = 32'd917;
            5'd21:   v = 32'd458;
            5'd22:   v = 32'd229;
            5'd23:   v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/motion_rep_counter_unit.sv]
// Each path to result valid ends in FINISH; a clear command or zero x on a non-squat sample
// skips to it; a squat passes MUL, DRAIN; others MUL, DRAIN, SQRT, CORDIC, ANGLE first.
// Arm work is set by the bit-serial square root (16 + ANGLE_FRAC_BITS pair steps) and the
// shared CORDIC stage (CORDIC_STEPS iterations); squat work by the shared squarer.
// One item at a time: the next item can be accepted in the cycle after the result is loaded.
// Reset (rst_n low, asynchronous): count and phases cleared, levels to defaults, no result.
`default_nettype none

`include "motion_rep_counter_unit_macros.svh"

module motion_rep_counter_unit #(
    parameter int COUNT_WIDTH     = mrc_pkg::COUNT_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = mrc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = mrc_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  wire logic [2:0]  s_tuser,   // action[0], exercise[2:1]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // rep_total[15:0], arm_phase[17:16],
                                        // squat_phase[19:18], tilt_degrees[27:20], zero
);

    localparam int F           = ANGLE_FRAC_BITS;
    localparam int SQRT_PAIRS  = 16 + F;
    localparam int RT          = 16 + F;           // root width
    localparam int RW          = RT + 3;           // remainder width
    localparam int NW          = 32 + 2 * F;       // radicand width
    localparam int CW          = 19 + F;           // CORDIC x/y width
    localparam int AW          = 10 + F;           // angle accumulator width
    localparam int CNT_MAX     = (SQRT_PAIRS > CORDIC_STEPS) ? SQRT_PAIRS : CORDIC_STEPS;
    localparam int CNT_W       = $clog2(CNT_MAX);
    localparam int CNT_EXT_W   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int RND_SHIFT   = mrc_pkg::TABLE_FRAC - F;

    mrc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]       cnt_reg;
    logic                   action_reg;
    logic [1:0]             exercise_reg;
    logic signed [15:0]     ax_reg, ay_reg, az_reg;

    logic [31:0]            prod_reg;
    logic [2:0]             prod_idx_reg;
    logic                   prod_vld_reg;
    logic [31:0]            sum_reg, down2_reg, up2_reg;

    logic [NW-1:0]          rad_reg;
    logic [RW-1:0]          rem_reg;
    logic [RT-1:0]          root_reg;

    logic signed [CW-1:0]   cx_reg, cy_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [7:0]             tilt_reg;

    logic [1:0]             arm_phase_reg, squat_phase_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    logic [15:0]            squat_down_reg, squat_up_reg;
    logic [7:0]             curl_start_reg, curl_end_reg, raise_start_reg, raise_end_reg;

    logic                   m_valid_reg;
    logic [31:0]            m_data_reg;

    // control decoded from state and the stream handshakes
    logic accept, out_free, finish_go;

    // input fields
    logic               in_action;
    logic [1:0]         in_exercise;
    logic [15:0]        in_x;

    assign in_action   = s_tuser[0];
    assign in_exercise = s_tuser[2:1];
    assign in_x        = s_tdata[15:0];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    logic [2:0] mul_last;
    assign mul_last = (exercise_reg == mrc_pkg::EX_SQUAT) ? mrc_pkg::TERM_UP : mrc_pkg::TERM_Z;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_action || (in_exercise != mrc_pkg::EX_SQUAT && in_x == 16'd0))
                        state_next = mrc_pkg::ST_FINISH;
                    else
                        state_next = mrc_pkg::ST_MUL;
                end
            end
            mrc_pkg::ST_MUL:
            begin
                if (cnt_reg[2:0] == mul_last)
                    state_next = mrc_pkg::ST_DRAIN;
            end
            mrc_pkg::ST_DRAIN:
            begin
                if (exercise_reg == mrc_pkg::EX_SQUAT)
                    state_next = mrc_pkg::ST_FINISH;
                else
                    state_next = mrc_pkg::ST_SQRT;
            end
            mrc_pkg::ST_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_PAIRS - 1))
                    state_next = mrc_pkg::ST_CORDIC;
            end
            mrc_pkg::ST_CORDIC:
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = mrc_pkg::ST_ANGLE;
            end
            mrc_pkg::ST_ANGLE:
            begin
                state_next = mrc_pkg::ST_FINISH;
            end
            mrc_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = mrc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mrc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready  = 1'b0;
        finish_go = 1'b0;
        case (state_reg)
            mrc_pkg::ST_IDLE:   s_tready  = 1'b1;
            mrc_pkg::ST_FINISH: finish_go = out_free;
            default:
            begin
                s_tready  = 1'b0;
                finish_go = 1'b0;
            end
        endcase
    end

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mrc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // shared squarer
    // ------------------------------------------------------------------
    logic signed [16:0] mul_op;
    logic signed [33:0] prod_full;

    always_comb
    begin
        case (cnt_reg[2:0])
            mrc_pkg::TERM_X:    mul_op = 17'(ax_reg);
            mrc_pkg::TERM_Y:    mul_op = 17'(ay_reg);
            mrc_pkg::TERM_Z:    mul_op = 17'(az_reg);
            mrc_pkg::TERM_DOWN: mul_op = $signed({1'b0, squat_down_reg});
            mrc_pkg::TERM_UP:   mul_op = $signed({1'b0, squat_up_reg});
            default:            mul_op = 17'sd0;
        endcase
    end

    assign prod_full = mul_op * mul_op;

    // ------------------------------------------------------------------
    // square root step: one pair of radicand bits a cycle
    // ------------------------------------------------------------------
    logic [RW-1:0] rem_cat, trial;
    logic          sq_ge;
    logic [RW-1:0] rem_step;
    logic [RT-1:0] root_step;

    assign rem_cat   = {rem_reg[RW-3:0], rad_reg[NW-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sq_ge     = (rem_cat >= trial);
    assign rem_step  = sq_ge ? (rem_cat - trial) : rem_cat;
    assign root_step = {root_reg[RT-2:0], sq_ge};

    // ------------------------------------------------------------------
    // CORDIC step
    // ------------------------------------------------------------------
    logic [31:0]          atan_raw, atan_rnd;
    logic signed [AW-1:0] atan_step;
    logic signed [CW-1:0] dx, dy;
    logic                 cy_pos;

    assign atan_raw  = mrc_pkg::atan_deg_q24(cnt_reg[mrc_pkg::TAB_IDX_W-1:0]);
    assign atan_rnd  = (atan_raw + (32'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    assign atan_step = $signed(atan_rnd[AW-1:0]);
    assign dx        = cy_reg >>> cnt_reg;
    assign dy        = cx_reg >>> cnt_reg;
    assign cy_pos    = (cy_reg > $signed(CW'(0)));

    // ------------------------------------------------------------------
    // angle to tilt: truncate toward zero, offset, clamp
    // ------------------------------------------------------------------
    logic                 acc_neg;
    logic [AW-1:0]        acc_mag;
    logic [AW-F-1:0]      deg_mag;
    logic signed [AW-F+1:0] deg_off;
    logic [7:0]           tilt_calc;

    assign acc_neg = acc_reg[AW-1];
    assign acc_mag = acc_neg ? AW'(-acc_reg) : AW'(acc_reg);
    assign deg_mag = acc_mag[AW-1:F];

    always_comb
    begin
        if (acc_neg)
            deg_off = -$signed({2'b00, deg_mag});
        else
            deg_off = $signed({2'b00, deg_mag});
        deg_off = deg_off + $signed((AW-F+2)'(mrc_pkg::TILT_LEVEL));
        if (deg_off < 0)
            tilt_calc = 8'd0;
        else if (deg_off > $signed((AW-F+2)'(mrc_pkg::TILT_MAX)))
            tilt_calc = mrc_pkg::TILT_MAX;
        else
            tilt_calc = deg_off[7:0];
    end

    // ------------------------------------------------------------------
    // phase machines and counter, resolved at finish
    // ------------------------------------------------------------------
    logic [1:0]             arm_phase_next, squat_phase_next;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   rep_inc;
    logic [7:0]             th_start, th_end;
    logic [CNT_EXT_W-1:0]   count_ext;
    logic [15:0]            rep_total;

    assign th_start = (exercise_reg == mrc_pkg::EX_CURL) ? curl_start_reg : raise_start_reg;
    assign th_end   = (exercise_reg == mrc_pkg::EX_CURL) ? curl_end_reg : raise_end_reg;

    always_comb
    begin
        arm_phase_next   = arm_phase_reg;
        squat_phase_next = squat_phase_reg;
        rep_inc          = 1'b0;
        count_next       = count_reg;
        if (action_reg)
        begin
            arm_phase_next   = mrc_pkg::ARM_REST;
            squat_phase_next = mrc_pkg::SQ_REST;
            count_next       = '0;
        end
        else if (exercise_reg == mrc_pkg::EX_SQUAT)
        begin
            case (squat_phase_reg)
                mrc_pkg::SQ_REST:
                begin
                    if (sum_reg < down2_reg)
                        squat_phase_next = mrc_pkg::SQ_DOWN;
                end
                mrc_pkg::SQ_DOWN:
                begin
                    if (sum_reg > up2_reg)
                        squat_phase_next = mrc_pkg::SQ_UP;
                end
                default:
                begin
                    if (sum_reg < down2_reg)
                    begin
                        rep_inc          = 1'b1;
                        squat_phase_next = mrc_pkg::SQ_DOWN;
                    end
                end
            endcase
        end
        else if (exercise_reg != mrc_pkg::EX_NONE)
        begin
            case (arm_phase_reg)
                mrc_pkg::ARM_REST:
                begin
                    if (tilt_reg < th_start)
                        arm_phase_next = mrc_pkg::ARM_LIFT;
                end
                mrc_pkg::ARM_LIFT:
                begin
                    if (tilt_reg < th_end)
                        arm_phase_next = mrc_pkg::ARM_LOWER;
                    else if (tilt_reg > th_start)
                        arm_phase_next = mrc_pkg::ARM_REST;
                end
                default:
                begin
                    if (tilt_reg > th_start)
                    begin
                        rep_inc        = 1'b1;
                        arm_phase_next = mrc_pkg::ARM_REST;
                    end
                end
            endcase
        end
        // hold at full scale
        if (rep_inc && (count_reg != {COUNT_WIDTH{1'b1}}))
            count_next = count_reg + COUNT_WIDTH'(1);
    end

    assign count_ext = CNT_EXT_W'(count_next);
    assign rep_total = (count_ext > CNT_EXT_W'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_vld_reg <= (state_reg == mrc_pkg::ST_MUL);
        prod_idx_reg <= cnt_reg[2:0];
        prod_reg     <= prod_full[31:0];

        if (accept)
        begin
            action_reg   <= in_action;
            exercise_reg <= in_exercise;
            ax_reg       <= $signed(s_tdata[15:0]);
            ay_reg       <= $signed(s_tdata[31:16]);
            az_reg       <= $signed(s_tdata[47:32]);
            sum_reg      <= '0;
            if (in_action || in_exercise == mrc_pkg::EX_SQUAT)
                tilt_reg <= 8'd0;
            else
                tilt_reg <= mrc_pkg::TILT_LEVEL;
        end
        else if (prod_vld_reg)
        begin
            case (prod_idx_reg)
                mrc_pkg::TERM_DOWN: down2_reg <= prod_reg;
                mrc_pkg::TERM_UP:   up2_reg   <= prod_reg;
                default:            sum_reg   <= sum_reg + prod_reg;
            endcase
        end

        case (state_reg)
            mrc_pkg::ST_IDLE:
            begin
                if (in_exercise == mrc_pkg::EX_SQUAT)
                    cnt_reg <= CNT_W'(mrc_pkg::TERM_X);
                else
                    cnt_reg <= CNT_W'(mrc_pkg::TERM_Y);
            end
            mrc_pkg::ST_MUL:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            mrc_pkg::ST_DRAIN:
            begin
                // fold in the last square on its way into the radicand
                cnt_reg  <= '0;
                rad_reg  <= {32'(sum_reg + prod_reg), {(2 * F){1'b0}}};
                rem_reg  <= '0;
                root_reg <= '0;
                cy_reg   <= $signed({{(CW - F - 16){ax_reg[15] ^ 1'b1}}, 16'(-ax_reg),
                                     {F{1'b0}}});
                acc_reg  <= '0;
            end
            mrc_pkg::ST_SQRT:
            begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_step;
                root_reg <= root_step;
                if (cnt_reg == CNT_W'(SQRT_PAIRS - 1))
                begin
                    cnt_reg <= '0;
                    cx_reg  <= $signed({{(CW - RT){1'b0}}, root_step});
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            mrc_pkg::ST_CORDIC:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cy_pos)
                begin
                    cx_reg  <= cx_reg + dx;
                    cy_reg  <= cy_reg - dy;
                    acc_reg <= acc_reg + atan_step;
                end
                else
                begin
                    cx_reg  <= cx_reg - dx;
                    cy_reg  <= cy_reg + dy;
                    acc_reg <= acc_reg - atan_step;
                end
            end
            mrc_pkg::ST_ANGLE:
            begin
                tilt_reg <= tilt_calc;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase

        if (finish_go)
            m_data_reg <= {4'b0000, tilt_reg, squat_phase_next, arm_phase_next, rep_total};
    end

    // ------------------------------------------------------------------
    // control state: machines, counter, levels, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_phase_reg   <= mrc_pkg::ARM_REST;
            squat_phase_reg <= mrc_pkg::SQ_REST;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (finish_go)
            begin
                arm_phase_reg   <= arm_phase_next;
                squat_phase_reg <= squat_phase_next;
                count_reg       <= count_next;
                m_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squat_down_reg  <= mrc_pkg::SQUAT_DOWN_RST;
            squat_up_reg    <= mrc_pkg::SQUAT_UP_RST;
            curl_start_reg  <= mrc_pkg::CURL_START_RST;
            curl_end_reg    <= mrc_pkg::CURL_END_RST;
            raise_start_reg <= mrc_pkg::RAISE_START_RST;
            raise_end_reg   <= mrc_pkg::RAISE_END_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrc_pkg::CFG_SQUAT_DOWN:  squat_down_reg  <= cfg_data;
                mrc_pkg::CFG_SQUAT_UP:    squat_up_reg    <= cfg_data;
                mrc_pkg::CFG_CURL_START:  curl_start_reg  <= cfg_data[7:0];
                mrc_pkg::CFG_CURL_END:    curl_end_reg    <= cfg_data[7:0];
                mrc_pkg::CFG_RAISE_START: raise_start_reg <= cfg_data[7:0];
                mrc_pkg::CFG_RAISE_END:   raise_end_reg   <= cfg_data[7:0];
                default:                  squat_down_reg  <= squat_down_reg;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MRC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `MRC_ASSERT_IMPLY(a_phase_codes, m_tvalid, m_tdata[17:16] != 2'b11 && m_tdata[19:18] != 2'b11)
    `MRC_ASSERT_IMPLY(a_tilt_range, m_tvalid, m_tdata[27:20] <= mrc_pkg::TILT_MAX)
    `MRC_ASSERT_IMPLY(a_cordic_x_nonneg, state_reg == mrc_pkg::ST_CORDIC, !cx_reg[CW-1])

endmodule

`default_nettype wire

[test/rep_counter_checker.sv]
module rep_counter_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  wire logic [2:0]  s_tuser,   // action[0], exercise[2:1]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // rep_total[15:0], arm_phase[17:16],
                                        // squat_phase[19:18], tilt_degrees[27:20], zero
    output int               fail_count,
    output int               outstanding
);
    import mrc_pkg::*;

    localparam int FRAC  = ANGLE_FRAC_BITS_DEF;
    localparam int STEPS = CORDIC_STEPS_DEF;

    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  tilt_degrees;
        logic [1:0]  squat_phase;
        logic [1:0]  arm_phase;
        logic [15:0] rep_total;
    } rep_result_t;

    // atan(2^-i) in degrees, scaled by 2^24
    longint atan_q24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic [15:0] down_lvl, up_lvl;
    logic [7:0]  curl_hi, curl_lo, raise_hi, raise_lo;
    logic [1:0]  arm_ph, squat_ph;
    logic [15:0] reps;

    rep_result_t pending_results [$];
    rep_result_t got, want;

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [7:0] tilt_of_sample(input longint x, input longint y,
                                                  input longint z);
        longint cx, cy, acc, step, dx, dy, deg;
        longint unsigned rsq;
        int i;
        if (x == 0)
            return TILT_LEVEL;
        rsq = longint'(y * y + z * z);
        cx = longint'(floor_sqrt(rsq << (2 * FRAC)));
        cy = -x * (longint'(1) << FRAC);
        acc = 0;
        // vectoring: drive cy toward zero, accumulate the angle in degrees
        for (i = 0; i < STEPS; i++)
        begin
            step = (atan_q24[i] + (longint'(1) << (TABLE_FRAC - FRAC - 1)))
                   >>> (TABLE_FRAC - FRAC);
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                acc = acc + step;
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                acc = acc - step;
            end
        end
        // truncate toward zero, then shift to 0..180
        deg = (acc >= 0) ? (acc >>> FRAC) : -((-acc) >>> FRAC);
        deg = deg + 90;
        if (deg < 0)
            deg = 0;
        if (deg > 180)
            deg = 180;
        return deg[7:0];
    endfunction

    function automatic void count_rep();
        if (reps != '1)
            reps = reps + 16'd1;
    endfunction

    function automatic rep_result_t predict_rep_result(input logic action,
                                                       input logic [1:0] exercise,
                                                       input logic signed [15:0] ax,
                                                       input logic signed [15:0] ay,
                                                       input logic signed [15:0] az);
        rep_result_t res;
        longint x, y, z;
        longint unsigned mag2, down2, up2;
        logic [7:0] tilt, hi, lo;
        x = ax;
        y = ay;
        z = az;
        tilt = '0;
        if (action)
        begin
            reps = '0;
            arm_ph = ARM_REST;
            squat_ph = SQ_REST;
        end
        else if (exercise == EX_SQUAT)
        begin
            mag2 = longint'(x * x + y * y + z * z);
            down2 = 64'(down_lvl) * 64'(down_lvl);
            up2 = 64'(up_lvl) * 64'(up_lvl);
            case (squat_ph)
                SQ_REST:
                    if (mag2 < down2)
                        squat_ph = SQ_DOWN;
                SQ_DOWN:
                    if (mag2 > up2)
                        squat_ph = SQ_UP;
                default:
                    if (mag2 < down2)
                    begin
                        count_rep();
                        squat_ph = SQ_DOWN;
                    end
            endcase
        end
        else
        begin
            tilt = tilt_of_sample(x, y, z);
            hi = (exercise == EX_CURL) ? curl_hi : raise_hi;
            lo = (exercise == EX_CURL) ? curl_lo : raise_lo;
            // thresholds are inverted: lifting lowers the tilt
            if (exercise != EX_NONE)
            begin
                case (arm_ph)
                    ARM_REST:
                        if (tilt < hi)
                            arm_ph = ARM_LIFT;
                    ARM_LIFT:
                        if (tilt < lo)
                            arm_ph = ARM_LOWER;
                        else if (tilt > hi)
                            arm_ph = ARM_REST;
                    default:
                        if (tilt > hi)
                        begin
                            count_rep();
                            arm_ph = ARM_REST;
                        end
                endcase
            end
        end
        res.pad = '0;
        res.tilt_degrees = tilt;
        res.squat_phase = squat_ph;
        res.arm_phase = arm_ph;
        res.rep_total = reps;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("rep counter mismatch, %s: got %0d, expected %0d at %0t",
                 what, got_v, want_v, $time);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_lvl = SQUAT_DOWN_RST;
            up_lvl = SQUAT_UP_RST;
            curl_hi = CURL_START_RST;
            curl_lo = CURL_END_RST;
            raise_hi = RAISE_START_RST;
            raise_lo = RAISE_END_RST;
            arm_ph = ARM_REST;
            squat_ph = SQ_REST;
            reps = '0;
            fail_count = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // a result transfer never belongs to a sample accepted at the same edge
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no sample pending", got, '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.rep_total !== want.rep_total)
                        report_mismatch("rep_total", 32'(got.rep_total),
                                        32'(want.rep_total));
                    if (got.arm_phase !== want.arm_phase)
                        report_mismatch("arm_phase", 32'(got.arm_phase),
                                        32'(want.arm_phase));
                    if (got.squat_phase !== want.squat_phase)
                        report_mismatch("squat_phase", 32'(got.squat_phase),
                                        32'(want.squat_phase));
                    if (got.tilt_degrees !== want.tilt_degrees)
                        report_mismatch("tilt_degrees", 32'(got.tilt_degrees),
                                        32'(want.tilt_degrees));
                    if (got.pad !== want.pad)
                        report_mismatch("padding bits", 32'(got.pad), 32'(want.pad));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SQUAT_DOWN:  down_lvl = cfg_data;
                    CFG_SQUAT_UP:    up_lvl = cfg_data;
                    CFG_CURL_START:  curl_hi = cfg_data[7:0];
                    CFG_CURL_END:    curl_lo = cfg_data[7:0];
                    CFG_RAISE_START: raise_hi = cfg_data[7:0];
                    CFG_RAISE_END:   raise_lo = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_rep_result(s_tuser[0], s_tuser[2:1],
                                                             s_tdata[15:0],
                                                             s_tdata[31:16],
                                                             s_tdata[47:32]));
            outstanding <= pending_results.size();
        end
    end

endmodule

[test/motion_rep_counter_unit_tb.sv]
module motion_rep_counter_unit_tb;
    import mrc_pkg::*;

    localparam real PI = 3.14159265358979;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic [2:0]  s_tuser = '0;   // action[0], exercise[2:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // rep_total[15:0], arm_phase[17:16],
                                 // squat_phase[19:18], tilt_degrees[27:20], zero

    int fail_count;
    int outstanding;
    int sent = 0;
    bit calm = 1'b0;

    // thresholds currently loaded, used to aim the generated motion
    logic [15:0] down_lvl = SQUAT_DOWN_RST;
    logic [15:0] up_lvl = SQUAT_UP_RST;
    logic [7:0]  curl_hi = CURL_START_RST;
    logic [7:0]  curl_lo = CURL_END_RST;
    logic [7:0]  raise_hi = RAISE_START_RST;
    logic [7:0]  raise_lo = RAISE_END_RST;

    motion_rep_counter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rep_counter_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    function automatic logic [47:0] axes(input int x, input int y, input int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [47:0] random_axes();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    function automatic int clip16(input real v);
        if (v > 32767.0)
            return 32767;
        if (v < -32768.0)
            return -32768;
        return int'(v);
    endfunction

    // sample whose pitch + 90 lands near the given tilt
    function automatic logic [47:0] tilted_axes(input real tilt_deg);
        real m, p, q, r;
        m = real'($urandom_range(30000, 256));
        p = (tilt_deg - 90.0) * PI / 180.0;
        q = real'($urandom_range(359, 0)) * PI / 180.0;
        r = m * $cos(p);
        return axes(clip16(-m * $sin(p)), clip16(r * $cos(q)), clip16(r * $sin(q)));
    endfunction

    // sample with roughly the given magnitude in a random direction
    function automatic logic [47:0] magnitude_axes(input int mag);
        real a, b;
        a = real'($urandom_range(359, 0)) * PI / 180.0;
        b = real'($urandom_range(359, 0)) * PI / 180.0;
        return axes(clip16(mag * $cos(a) * $cos(b)), clip16(mag * $cos(a) * $sin(b)),
                    clip16(mag * $sin(a)));
    endfunction

    function automatic real pick_deg(input int lo, input int hi);
        int a, b;
        a = (lo < 0) ? 0 : ((lo > 180) ? 180 : lo);
        b = (hi > 180) ? 180 : hi;
        if (b < a)
            b = a;
        return real'($urandom_range(b, a)) + real'($urandom_range(99, 0)) / 100.0;
    endfunction

    task automatic send_item(input logic action, input logic [1:0] exercise,
                             input logic [47:0] accel);
        int gap;
        gap = calm ? 0 : $urandom_range(13, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= accel;
        s_tuser <= {exercise, action};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic send_noise();
        send_item($urandom_range(15, 0) == 0, 2'($urandom_range(3, 0)), random_axes());
    endtask

    // hold the input until the checker has seen every result
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_levels(input logic [15:0] down, input logic [15:0] up,
                               input logic [7:0] c_hi, input logic [7:0] c_lo,
                               input logic [7:0] r_hi, input logic [7:0] r_lo);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SQUAT_DOWN;
        cfg_data <= down;
        @(posedge clk);
        cfg_index <= CFG_SQUAT_UP;
        cfg_data <= up;
        @(posedge clk);
        cfg_index <= CFG_CURL_START;
        cfg_data <= {8'h00, c_hi};
        @(posedge clk);
        cfg_index <= CFG_CURL_END;
        cfg_data <= {8'h00, c_lo};
        @(posedge clk);
        cfg_index <= CFG_RAISE_START;
        cfg_data <= {8'h00, r_hi};
        @(posedge clk);
        cfg_index <= CFG_RAISE_END;
        cfg_data <= {8'h00, r_lo};
        @(posedge clk);
        cfg_we <= 1'b0;
        down_lvl = down;
        up_lvl = up;
        curl_hi = c_hi;
        curl_lo = c_lo;
        raise_hi = r_hi;
        raise_lo = r_lo;
    endtask

    // lift, top, back to rest; a broken rep drops back or clears after the lift
    task automatic arm_reps(input logic [1:0] ex, input int count, input bit broken);
        int hi, lo, k;
        hi = (ex == EX_CURL) ? int'(curl_hi) : int'(raise_hi);
        lo = (ex == EX_CURL) ? int'(curl_lo) : int'(raise_lo);
        for (k = 0; k < count; k++)
        begin
            send_item(1'b0, ex, tilted_axes(pick_deg(lo + 1, hi - 1)));
            if ($urandom_range(4, 0) == 0)
                send_item(1'b0, EX_NONE, random_axes());
            if (broken && $urandom_range(1, 0) == 0)
            begin
                send_item(1'b0, ex, tilted_axes(pick_deg(hi + 1, 180)));
            end
            else if (broken)
            begin
                send_item(1'b1, ex, random_axes());
            end
            else
            begin
                send_item(1'b0, ex, tilted_axes(pick_deg(0, lo - 1)));
                if ($urandom_range(5, 0) == 0)
                    send_item(1'b0, ex, tilted_axes(pick_deg(lo, hi)));
                send_item(1'b0, ex, tilted_axes(pick_deg(hi + 1, 180)));
            end
        end
    endtask

    task automatic squat_reps(input int count, input bit broken);
        int k, dn, up;
        dn = int'(down_lvl);
        up = int'(up_lvl);
        send_item(1'b0, EX_SQUAT, magnitude_axes((dn > 0) ? $urandom_range(dn - 1, 0) : 0));
        for (k = 0; k < count; k++)
        begin
            if (broken && $urandom_range(2, 0) == 0)
                send_item(1'b1, EX_SQUAT, random_axes());
            else
                send_item(1'b0, EX_SQUAT,
                          magnitude_axes($urandom_range(56000, (up < 55999) ? up + 1 : 56000)));
            if ($urandom_range(5, 0) == 0)
                send_noise();
            send_item(1'b0, EX_SQUAT,
                      magnitude_axes((dn > 0) ? $urandom_range(dn - 1, 0) : 0));
        end
    endtask

    // result side: random stall ahead of every result unless calm is set
    initial
    begin
        int stall;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(13, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        #60000000;
        $display("motion_rep_counter_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        int phase, phase_end, kind, guard;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset thresholds
        send_item(1'b1, EX_SQUAT, random_axes());
        send_item(1'b0, EX_SQUAT, axes(-32768, -32768, -32768));
        send_item(1'b0, EX_SQUAT, axes(0, 0, 0));
        send_item(1'b0, EX_SQUAT, axes(8000, 0, 0));
        send_item(1'b0, EX_SQUAT, axes(1000, 0, 0));
        send_item(1'b0, EX_SQUAT, axes(32767, 32767, 32767));
        send_item(1'b0, EX_CURL, axes(0, 0, 0));
        send_item(1'b0, EX_CURL, axes(4096, 0, 4096));
        send_item(1'b0, EX_CURL, axes(-32768, 0, 0));
        send_item(1'b0, EX_CURL, axes(32767, 0, 0));
        send_item(1'b0, EX_NONE, axes(-32768, -32768, -32768));
        send_item(1'b0, EX_NONE, axes(32767, 32767, 32767));
        send_item(1'b0, EX_CURL, axes(1, -32768, -32768));
        send_item(1'b0, EX_RAISE, axes(0, 5000, -5000));
        send_item(1'b0, EX_RAISE, axes(-1, 0, 0));
        send_item(1'b0, EX_RAISE, axes(0, 32767, 0));
        send_item(1'b0, EX_RAISE, axes(358, 4096, 0));
        send_item(1'b0, EX_RAISE, axes(-20000, 100, 0));
        send_item(1'b1, EX_NONE, axes(-32768, 32767, -32768));
        send_item(1'b0, EX_NONE, axes(0, 0, 0));
        wait_for_results();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0, 4: load_levels(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                                  8'($urandom_range(180, 0)), 8'($urandom_range(180, 0)),
                                  8'($urandom_range(180, 0)), 8'($urandom_range(180, 0)));
                1: load_levels(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: load_levels(16'hFFFF, 16'hFFFF, TILT_MAX, TILT_MAX, TILT_MAX, TILT_MAX);
                3: load_levels(16'd0, 16'hFFFF, TILT_MAX, 8'd0, TILT_MAX, 8'd0);
                default: load_levels(SQUAT_DOWN_RST, SQUAT_UP_RST, CURL_START_RST,
                                     CURL_END_RST, RAISE_START_RST, RAISE_END_RST);
            endcase
            phase_end = sent + 145;
            while (sent < phase_end)
            begin
                calm = ($urandom_range(5, 0) == 0);
                kind = $urandom_range(9, 0);
                if (kind < 6)
                begin
                    case ($urandom_range(2, 0))
                        0: squat_reps($urandom_range(4, 1), 1'b0);
                        1: arm_reps(EX_CURL, $urandom_range(4, 1), 1'b0);
                        default: arm_reps(EX_RAISE, $urandom_range(4, 1), 1'b0);
                    endcase
                end
                else if (kind < 8)
                begin
                    repeat ($urandom_range(6, 1)) send_noise();
                end
                else
                begin
                    case ($urandom_range(2, 0))
                        0: squat_reps($urandom_range(3, 1), 1'b1);
                        1: arm_reps(EX_CURL, $urandom_range(3, 1), 1'b1);
                        default: arm_reps(EX_RAISE, $urandom_range(3, 1), 1'b1);
                    endcase
                end
            end
            calm = 1'b0;
            wait_for_results();
        end

        // run a burst of back-to-back squats with no idle cycles
        calm = 1'b1;
        send_item(1'b1, EX_SQUAT, axes(0, 0, 0));
        send_item(1'b0, EX_SQUAT, axes(1000, 0, 0));
        repeat (8)
        begin
            send_item(1'b0, EX_SQUAT, axes(8000, 0, 0));
            send_item(1'b0, EX_SQUAT, axes(1000, 0, 0));
        end
        calm = 1'b0;
        send_item(1'b0, EX_CURL, axes(0, 0, 0));
        send_item(1'b0, EX_CURL, axes(4096, 0, 4096));
        send_item(1'b0, EX_CURL, axes(-32768, 0, 0));
        send_item(1'b1, EX_CURL, random_axes());
        send_item(1'b0, EX_SQUAT, axes(1000, 0, 0));

        s_tvalid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (outstanding != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (64) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("motion_rep_counter_unit_tb: done, clean");
        else
            $display("motion_rep_counter_unit_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/mrc_pkg.sv
hdl/motion_rep_counter_unit.sv
test/rep_counter_checker.sv
test/motion_rep_counter_unit_tb.sv
